/* src/grid_region_size_flood_fill_top_defines.svh */
// assertion macros shared by the flood fill rtl
// no dependencies; included by the files that carry assertions
`ifndef GRID_REGION_SIZE_FLOOD_FILL_TOP_DEFINES_SVH
`define GRID_REGION_SIZE_FLOOD_FILL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// checked property, switched off while reset is high
`define GSFF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, evaluated on every edge including reset
`define GSFF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSFF_ASSERT(lbl, clk, rst, prop, msg)
`define GSFF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* src/gsff_pkg.sv */
// types and constants of the region size flood fill block
// no dependencies; used by the controller, the datapath and the top level
package gsff_pkg;

   localparam int COORD_W = 6;
   localparam int CSR_W   = 7;
   localparam int COUNT_W = 13;

   localparam logic [CSR_W-1:0]   SIDE_RESET = 7'd64;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'h1fff;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // cell word: bit 1 marked, bit 0 visited
   localparam logic [1:0] CELL_EMPTY = 2'b00;
   localparam logic [1:0] CELL_FRESH = 2'b10;
   localparam logic [1:0] CELL_SEEN  = 2'b11;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_POP,
      ST_NBR,
      ST_TAIL,
      ST_DONE_ZERO,
      ST_DONE_CNT
   } state_type;

   typedef enum logic [1:0] {
      DIR_XP,
      DIR_YP,
      DIR_XM,
      DIR_YM
   } dir_type;

   typedef struct packed {
      logic    clr_step;
      logic    cell_wr;
      logic    start_rd;
      logic    start_take;
      logic    pop;
      logic    nb_issue;
      logic    nb_eval;
      dir_type dir;
      logic    out_load;
      logic    out_zero;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic start_in;
      logic start_hit;
      logic stack_empty;
      logic out_free;
   } sts_type;

endpackage

/* src/gsff_ctrl.sv */
// controller state machine of the flood fill block
// depends on gsff_pkg and the assertion macro header
`include "grid_region_size_flood_fill_top_defines.svh"

module gsff_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   output logic             req_stall,
   input  gsff_pkg::sts_type sts,
   output gsff_pkg::cmd_type cmd
);

   gsff_pkg::state_type state_ff, state_in;
   gsff_pkg::dir_type   dir_ff, dir_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsff_pkg::ST_CLEAR;
         dir_ff   <= gsff_pkg::DIR_XP;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      case (state_ff)
         gsff_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = gsff_pkg::ST_IDLE;
         end
         gsff_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_func == gsff_pkg::FUNC_QUERY && sts.start_in)
                  state_in = gsff_pkg::ST_START;
               else
                  state_in = gsff_pkg::ST_DONE_ZERO;
            end
         end
         gsff_pkg::ST_START: begin
            state_in = sts.start_hit ? gsff_pkg::ST_POP : gsff_pkg::ST_DONE_ZERO;
         end
         gsff_pkg::ST_POP: begin
            if (sts.stack_empty) begin
               state_in = gsff_pkg::ST_DONE_CNT;
            end else begin
               state_in = gsff_pkg::ST_NBR;
               dir_in   = gsff_pkg::DIR_XP;
            end
         end
         gsff_pkg::ST_NBR: begin
            if (dir_ff == gsff_pkg::DIR_YM) state_in = gsff_pkg::ST_TAIL;
            else dir_in = gsff_pkg::dir_type'(2'(dir_ff + 2'd1));
         end
         gsff_pkg::ST_TAIL: begin
            state_in = gsff_pkg::ST_POP;
         end
         gsff_pkg::ST_DONE_ZERO, gsff_pkg::ST_DONE_CNT: begin
            if (sts.out_free) state_in = gsff_pkg::ST_IDLE;
         end
         default: begin
            state_in = gsff_pkg::ST_CLEAR;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      cmd.dir   = dir_ff;
      req_stall = 1'b1;
      case (state_ff)
         gsff_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         gsff_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_func == gsff_pkg::FUNC_WRITE) cmd.cell_wr = 1'b1;
               else if (sts.start_in) cmd.start_rd = 1'b1;
            end
         end
         gsff_pkg::ST_START: begin
            cmd.start_take = sts.start_hit;
         end
         gsff_pkg::ST_POP: begin
            cmd.pop = !sts.stack_empty;
         end
         gsff_pkg::ST_NBR: begin
            cmd.nb_issue = 1'b1;
            cmd.nb_eval  = 1'b1;
         end
         gsff_pkg::ST_TAIL: begin
            cmd.nb_eval = 1'b1;
         end
         gsff_pkg::ST_DONE_ZERO: begin
            cmd.out_load = sts.out_free;
            cmd.out_zero = 1'b1;
         end
         gsff_pkg::ST_DONE_CNT: begin
            cmd.out_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `GSFF_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> state_ff == gsff_pkg::ST_CLEAR, "reset must restart the clearing pass")
   `GSFF_ASSERT(a_accept_leaves_idle, clock, reset, (state_ff == gsff_pkg::ST_IDLE) && req_valid |=> state_ff != gsff_pkg::ST_IDLE, "accepted beat left controller idle")
   `GSFF_ASSERT(a_tail_after_last_dir, clock, reset, state_ff == gsff_pkg::ST_TAIL |-> $past(state_ff) == gsff_pkg::ST_NBR && $past(dir_ff) == gsff_pkg::DIR_YM, "tail reached before all four neighbors")

endmodule

/* src/gsff_dp.sv */
// datapath of the flood fill block: cell memory, pending stack, counter
// depends on gsff_pkg and the assertion macro header
`include "grid_region_size_flood_fill_top_defines.svh"

module gsff_dp #(
   parameter int MAX_SIDE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [gsff_pkg::COORD_W-1:0]      req_col,
   input  logic [gsff_pkg::COORD_W-1:0]      req_row,
   input  logic                              req_is_marked,
   input  logic                              csr_wr_en,
   input  logic [gsff_pkg::CSR_W-1:0]        csr_wr_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [gsff_pkg::COUNT_W-1:0]      rsp_region_size,
   input  gsff_pkg::cmd_type                 cmd,
   output gsff_pkg::sts_type                 sts
);

   localparam int CW    = $clog2(MAX_SIDE);
   localparam int AW    = 2 * CW;
   localparam int DEPTH = 2 ** AW;
   localparam int XW    = ($clog2(MAX_SIDE + 1) > gsff_pkg::CSR_W) ?
                          $clog2(MAX_SIDE + 1) : gsff_pkg::CSR_W;
   localparam logic [XW-1:0] MAX_X = XW'(MAX_SIDE);

   logic [gsff_pkg::CSR_W-1:0] grid_side_ff;
   logic [XW-1:0]              side_x, side_use;
   logic [XW-1:0]              col_x, row_x;
   logic [AW-1:0]              req_addr;
   logic                       wr_in_range;

   logic [1:0]    cell_mem [DEPTH];
   logic [1:0]    cell_rd_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [1:0]    mem_wd;

   logic [AW-1:0] stk_mem [DEPTH];
   logic [AW-1:0] stk_rd_ff;
   logic [AW:0]   sp_ff, sp_in, sp_dec;
   logic          push;
   logic [AW-1:0] push_addr, push_idx;

   logic [AW-1:0] clr_ff;
   logic [AW-1:0] start_addr_ff;
   logic [AW-1:0] chk_addr_ff;
   logic          chk_ok_ff;
   logic          nb_hit;

   logic [CW-1:0] px, py, nx, ny;
   logic [XW-1:0] px_x, py_x;
   logic          nb_ok;
   logic [AW-1:0] nb_addr;

   logic [gsff_pkg::COUNT_W-1:0] cnt_ff;
   logic                         rsp_valid_ff;
   logic [gsff_pkg::COUNT_W-1:0] rsp_size_ff;

   // configuration and side clamp
   always_ff @(posedge clock) begin
      if (reset) grid_side_ff <= gsff_pkg::SIDE_RESET;
      else if (csr_wr_en) grid_side_ff <= csr_wr_data;
   end

   assign side_x   = XW'(grid_side_ff);
   assign side_use = (side_x > MAX_X) ? MAX_X : side_x;
   assign col_x    = XW'(req_col);
   assign row_x    = XW'(req_row);
   assign req_addr = {row_x[CW-1:0], col_x[CW-1:0]};
   assign wr_in_range = (col_x < MAX_X) && (row_x < MAX_X);

   // neighbor address of the popped cell
   assign px   = stk_rd_ff[CW-1:0];
   assign py   = stk_rd_ff[AW-1:CW];
   assign px_x = XW'(px);
   assign py_x = XW'(py);

   always_comb begin
      nx    = px;
      ny    = py;
      nb_ok = 1'b0;
      case (cmd.dir)
         gsff_pkg::DIR_XP: begin
            nx    = CW'(px + 1'b1);
            nb_ok = (px_x + XW'(1)) < side_use;
         end
         gsff_pkg::DIR_YP: begin
            ny    = CW'(py + 1'b1);
            nb_ok = (py_x + XW'(1)) < side_use;
         end
         gsff_pkg::DIR_XM: begin
            nx    = CW'(px - 1'b1);
            nb_ok = px != '0;
         end
         gsff_pkg::DIR_YM: begin
            ny    = CW'(py - 1'b1);
            nb_ok = py != '0;
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   assign nb_addr = {ny, nx};
   assign nb_hit  = cmd.nb_eval && chk_ok_ff && (cell_rd_ff == gsff_pkg::CELL_FRESH);

   always_ff @(posedge clock) begin
      if (reset) chk_ok_ff <= 1'b0;
      else chk_ok_ff <= cmd.nb_issue && nb_ok;
   end

   always_ff @(posedge clock) begin
      if (cmd.nb_issue) chk_addr_ff <= nb_addr;
      if (cmd.start_rd) start_addr_ff <= req_addr;
   end

   // cell memory port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = req_addr;
      mem_wd = gsff_pkg::CELL_EMPTY;
      if (cmd.clr_step) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
      end else if (cmd.cell_wr && wr_in_range) begin
         mem_we = 1'b1;
         mem_wd = {req_is_marked, 1'b0};
      end else if (cmd.start_take) begin
         mem_we = 1'b1;
         mem_wa = start_addr_ff;
         mem_wd = gsff_pkg::CELL_SEEN;
      end else if (nb_hit) begin
         mem_we = 1'b1;
         mem_wa = chk_addr_ff;
         mem_wd = gsff_pkg::CELL_SEEN;
      end
   end

   assign mem_re = cmd.start_rd || cmd.nb_issue;
   assign mem_ra = cmd.start_rd ? req_addr : nb_addr;

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[mem_wa] <= mem_wd;
      if (mem_re) cell_rd_ff <= cell_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= AW'(clr_ff + 1'b1);
   end

   // pending stack
   assign push      = cmd.start_take || nb_hit;
   assign push_addr = cmd.start_take ? start_addr_ff : chk_addr_ff;
   assign push_idx  = cmd.start_take ? '0 : sp_ff[AW-1:0];
   assign sp_dec    = sp_ff - 1'b1;

   always_comb begin
      sp_in = sp_ff;
      if (cmd.start_take) sp_in = (AW+1)'(1);
      else if (nb_hit) sp_in = (AW+1)'(sp_ff + 1'b1);
      else if (cmd.pop) sp_in = sp_dec;
   end

   always_ff @(posedge clock) begin
      if (reset) sp_ff <= '0;
      else sp_ff <= sp_in;
   end

   always_ff @(posedge clock) begin
      if (push) stk_mem[push_idx] <= push_addr;
      if (cmd.pop) stk_rd_ff <= stk_mem[sp_dec[AW-1:0]];
   end

   // region counter, saturating
   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else if (cmd.start_take) cnt_ff <= '0;
      else if (cmd.pop && cnt_ff != gsff_pkg::COUNT_MAX)
         cnt_ff <= gsff_pkg::COUNT_W'(cnt_ff + 1'b1);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) rsp_size_ff <= cmd.out_zero ? '0 : cnt_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_region_size = rsp_size_ff;

   assign sts.clr_last    = &clr_ff;
   assign sts.start_in    = (col_x < side_use) && (row_x < side_use);
   assign sts.start_hit   = cell_rd_ff == gsff_pkg::CELL_FRESH;
   assign sts.stack_empty = sp_ff == '0;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   `GSFF_ASSERT(a_load_when_free, clock, reset, cmd.out_load |-> !rsp_valid_ff || !rsp_stall, "result register overwritten while held")
   `GSFF_ASSERT(a_pop_not_empty, clock, reset, cmd.pop |-> sp_ff != '0, "pop from an empty stack")
   `GSFF_ASSERT(a_push_grows, clock, reset, nb_hit |=> sp_ff == $past(sp_ff) + 1'b1, "neighbor push did not advance the stack")

endmodule

/* src/grid_region_size_flood_fill_top.sv */
// top level of the region size flood fill block
// depends on gsff_pkg, gsff_ctrl, gsff_dp and the assertion macro header
// a cell write or a rejected query is answered from ST_DONE_ZERO with a size of zero
// a query walks its region cell by cell: pop, four neighbor probes, push slot
// one beat at a time: req_stall stays high from acceptance until the answer is loaded
// reset: synchronous; clears all 4**ceil(log2(MAX_SIDE)) cells of the grid in a pass, one
// cell per cycle, with req_stall high; csr writes still land
`include "grid_region_size_flood_fill_top_defines.svh"

module grid_region_size_flood_fill_top #(
   parameter int MAX_SIDE = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [gsff_pkg::COORD_W-1:0] req_col,
   input  logic [gsff_pkg::COORD_W-1:0] req_row,
   input  logic                         req_is_marked,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gsff_pkg::COUNT_W-1:0] rsp_region_size,
   // grid side register
   input  logic                         csr_wr_en,
   input  logic [gsff_pkg::CSR_W-1:0]   csr_wr_data
);

   // commands down from the controller, status back up
   gsff_pkg::cmd_type cmd;
   gsff_pkg::sts_type sts;

   // the controller walks clear, idle, start check, then pop / neighbor rounds
   gsff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // the datapath owns the cell memory, the pending stack and the result register,
   // so a finished beat waits there while the next request is taken
   gsff_dp #(
      .MAX_SIDE (MAX_SIDE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_is_marked   (req_is_marked),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_region_size (rsp_region_size),
      .cmd             (cmd),
      .sts             (sts)
   );

   // the response register must come out of reset empty
   `GSFF_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for grid_region_size_flood_fill_top: directed table, then random phases
// depends on gsff_pkg and the rtl of the block; carries its own flood fill predictor
module tb_top;

   localparam int GRID_MAX    = 64;
   localparam int CELL_COUNT  = GRID_MAX * GRID_MAX;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int MISS_SHOWN  = 10;
   localparam int COORD_BITS  = gsff_pkg::COORD_W;
   localparam int COUNT_BITS  = gsff_pkg::COUNT_W;
   localparam int CSR_BITS    = gsff_pkg::CSR_W;

   // how a beat's result is checked: a size typed into the table, or the predictor
   localparam logic FIXED   = 1'b1;
   localparam logic PREDICT = 1'b0;

   typedef struct packed {
      logic                  func;
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic                  mk;
      logic                  fixed;
      logic [COUNT_BITS-1:0] fixed_size;
   } cell_req_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_func;
   logic [COORD_BITS-1:0] req_col;
   logic [COORD_BITS-1:0] req_row;
   logic                  req_is_marked;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [COUNT_BITS-1:0] rsp_region_size;
   logic                  csr_wr_en;
   logic [CSR_BITS-1:0]   csr_wr_data;

   // checking mode of the beat on the bus, held with the payload
   logic                  beat_fixed;
   logic [COUNT_BITS-1:0] beat_fixed_size;

   // predictor state
   bit                    mark_map [CELL_COUNT];
   bit                    seen_map [CELL_COUNT];
   int unsigned           fill_stack [CELL_COUNT];
   logic [CSR_BITS-1:0]   side_copy;

   logic [COUNT_BITS-1:0] size_due_q [$];
   int                    fail_count;
   int                    rsp_count;
   int                    cycles;

   // directed beats at the reset side of 64
   cell_req_type directed_rows [0:22] = '{
      '{gsff_pkg::FUNC_QUERY,  6'd0,  6'd0, 1'b1, FIXED,   13'd0},  // query after reset: unmarked
      '{gsff_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_QUERY, 6'd63, 6'd63, 1'b0, FIXED,   13'd1},  // lone cell in the far corner
      '{gsff_pkg::FUNC_QUERY, 6'd63, 6'd63, 1'b0, FIXED,   13'd0},  // already visited
      '{gsff_pkg::FUNC_WRITE,  6'd0,  6'd0, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_WRITE,  6'd1,  6'd0, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_WRITE,  6'd0,  6'd1, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_WRITE,  6'd1,  6'd1, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_QUERY,  6'd1,  6'd1, 1'b0, FIXED,   13'd4},  // 2x2 block at the origin
      '{gsff_pkg::FUNC_WRITE, 6'd42, 6'd21, 1'b1, FIXED,   13'd0},  // alternating coordinate bits
      '{gsff_pkg::FUNC_WRITE, 6'd21, 6'd42, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_WRITE, 6'd42, 6'd22, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_QUERY, 6'd42, 6'd21, 1'b1, FIXED,   13'd2},  // marked bit ignored by queries
      '{gsff_pkg::FUNC_QUERY, 6'd42, 6'd22, 1'b0, FIXED,   13'd0},
      '{gsff_pkg::FUNC_WRITE, 6'd63, 6'd62, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_QUERY, 6'd63, 6'd62, 1'b0, FIXED,   13'd1},  // neighbor already visited
      '{gsff_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1, FIXED,   13'd0},  // rewrite clears visited
      '{gsff_pkg::FUNC_QUERY, 6'd63, 6'd63, 1'b0, FIXED,   13'd1},
      '{gsff_pkg::FUNC_WRITE,  6'd0,  6'd0, 1'b0, FIXED,   13'd0},  // unmark
      '{gsff_pkg::FUNC_WRITE,  6'd1,  6'd0, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_QUERY,  6'd1,  6'd0, 1'b0, FIXED,   13'd1},
      '{gsff_pkg::FUNC_QUERY,  6'd0,  6'd0, 1'b1, FIXED,   13'd0},
      '{gsff_pkg::FUNC_QUERY, 6'd21, 6'd42, 1'b0, PREDICT, 13'd0}
   };

   grid_region_size_flood_fill_top #(
      .MAX_SIDE (GRID_MAX)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_is_marked   (req_is_marked),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_region_size (rsp_region_size),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // applies one beat to the predictor state and returns the size it should answer
   function automatic logic [COUNT_BITS-1:0] region_size_after(cell_req_type b);
      int unsigned side;
      int unsigned addr;
      int unsigned sp;
      int unsigned filled;
      int unsigned cur;
      int          nx;
      int          ny;
      addr = b.row * GRID_MAX + b.col;
      if (b.func == gsff_pkg::FUNC_WRITE) begin
         mark_map[addr] = b.mk;
         seen_map[addr] = 1'b0;
         return '0;
      end
      side = (side_copy > GRID_MAX) ? GRID_MAX : side_copy;
      if (b.col >= side || b.row >= side || !mark_map[addr] || seen_map[addr])
         return '0;
      // depth-first walk; the count does not depend on visiting order
      seen_map[addr] = 1'b1;
      fill_stack[0] = addr;
      sp = 1;
      filled = 0;
      while (sp > 0) begin
         sp = sp - 1;
         cur = fill_stack[sp];
         filled = filled + 1;
         for (int k = 0; k < 4; k++) begin
            nx = int'(cur % GRID_MAX) + ((k == 0) ? 1 : (k == 2) ? -1 : 0);
            ny = int'(cur / GRID_MAX) + ((k == 1) ? 1 : (k == 3) ? -1 : 0);
            if (nx < 0 || ny < 0 || nx >= int'(side) || ny >= int'(side))
               continue;
            addr = ny * GRID_MAX + nx;
            if (!mark_map[addr] || seen_map[addr])
               continue;
            seen_map[addr] = 1'b1;
            fill_stack[sp] = addr;
            sp = sp + 1;
         end
      end
      return (filled > gsff_pkg::COUNT_MAX) ? gsff_pkg::COUNT_MAX : filled[COUNT_BITS-1:0];
   endfunction

   // monitor: register copy, predictions on accepted requests, checks on accepted responses
   always @(posedge clock) begin
      logic [COUNT_BITS-1:0] due;
      logic [COUNT_BITS-1:0] predicted;
      if (reset) begin
         side_copy = gsff_pkg::SIDE_RESET;
      end else begin
         if (csr_wr_en)
            side_copy = csr_wr_data;
         if (req_valid && !req_stall) begin
            // state moves with every beat, even when the table gives the size
            predicted = region_size_after('{req_func, req_col, req_row, req_is_marked,
                                           beat_fixed, beat_fixed_size});
            size_due_q.push_back(beat_fixed ? beat_fixed_size : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count = rsp_count + 1;
            if (size_due_q.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= MISS_SHOWN)
                  $display("response beat %0d arrived with nothing pending, size %0d",
                           rsp_count, rsp_region_size);
            end else begin
               due = size_due_q.pop_front();
               if (rsp_region_size !== due) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= MISS_SHOWN)
                     $display("response beat %0d: region_size expected %0d, got %0d",
                              rsp_count, due, rsp_region_size);
               end
            end
         end
      end
   end

   // timeout watchdog
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles = cycles + 1;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: runs of free flow, random stalls and solid stalls, plus one long hold-off
   initial begin
      int  run_len;
      int  mode;
      bit  held;
      held = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!held && rsp_count >= 30) begin
            // long hold-off so the block backs up and stalls its request side
            held = 1'b1;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            run_len = $urandom_range(1, 24);
            mode = $urandom_range(0, 3);
            repeat (run_len) begin
               case (mode)
                  0: rsp_stall = 1'b0;
                  1: rsp_stall = 1'($urandom_range(0, 1));
                  2: rsp_stall = ($urandom_range(0, 3) == 0);
                  default: rsp_stall = 1'b1;
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // puts one beat on the request bus at a falling edge and holds it until accepted
   task automatic drive_beat(input cell_req_type b);
      req_func = b.func;
      req_col = b.col;
      req_row = b.row;
      req_is_marked = b.mk;
      beat_fixed = b.fixed;
      beat_fixed_size = b.fixed_size;
      req_valid = 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   // sender side: bursts of beats with random gaps between them
   int burst_left;

   task automatic pace_sender();
      int gap;
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // idle the request bus, let every pending response come back, then write the side
   task automatic set_side(input logic [CSR_BITS-1:0] side);
      req_valid = 1'b0;
      while (size_due_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = side;
      @(negedge clock);
      csr_wr_en = 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [CSR_BITS-1:0]     phase_side [6];
      int                      phase_items [6];
      logic [2*COORD_BITS-1:0] written_q [$];
      cell_req_type            b;
      int                      eff;
      int                      span;
      int                      pick;
      int                      drain;

      reset = 1'b1;
      req_valid = 1'b0;
      req_func = gsff_pkg::FUNC_WRITE;
      req_col = '0;
      req_row = '0;
      req_is_marked = 1'b0;
      beat_fixed = PREDICT;
      beat_fixed_size = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      fail_count = 0;
      rsp_count = 0;
      burst_left = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; the block runs its clearing pass first with the request side stalled
      foreach (directed_rows[i]) begin
         drive_beat(directed_rows[i]);
         pace_sender();
      end

      // side settings: above the maximum, one, zero, small, random, full
      phase_side[0] = 7'd127;  phase_items[0] = 15;
      phase_side[1] = 7'd1;    phase_items[1] = 5;
      phase_side[2] = 7'd0;    phase_items[2] = 5;
      phase_side[3] = 7'd8;    phase_items[3] = 20;
      phase_side[4] = CSR_BITS'($urandom_range(2, 63));
      phase_items[4] = 20;
      phase_side[5] = 7'd64;   phase_items[5] = 12;

      for (int p = 0; p < 6; p++) begin
         set_side(phase_side[p]);
         eff = (phase_side[p] > GRID_MAX) ? GRID_MAX : phase_side[p];
         // keep most coordinates in a small window so regions grow; below a side of 12 the
         // window reaches at least one past the side and lands writes outside the grid in use
         span = (eff == 0) ? 3 : (eff >= 12) ? 12 : eff;
         for (int n = 0; n < phase_items[p]; n++) begin
            b.fixed = PREDICT;
            b.fixed_size = '0;
            b.mk = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
               b.col = COORD_BITS'($urandom_range(0, GRID_MAX - 1));
               b.row = COORD_BITS'($urandom_range(0, GRID_MAX - 1));
            end else begin
               b.col = COORD_BITS'($urandom_range(0, span));
               b.row = COORD_BITS'($urandom_range(0, span));
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               b.func = gsff_pkg::FUNC_WRITE;
               b.mk = ($urandom_range(0, 3) != 0);
               written_q.push_back({b.row, b.col});
               if (written_q.size() > 16)
                  void'(written_q.pop_front());
            end else begin
               // mostly query a cell written lately, the rest is noise
               b.func = gsff_pkg::FUNC_QUERY;
               if (pick < 85 && written_q.size() != 0)
                  {b.row, b.col} = written_q[$urandom_range(0, written_q.size() - 1)];
            end
            drive_beat(b);
            pace_sender();
         end
      end

      // drain, then a short tail for any stray response
      req_valid = 1'b0;
      drain = 0;
      while (size_due_q.size() != 0 && drain < CYCLE_LIMIT) begin
         @(posedge clock);
         drain = drain + 1;
      end
      repeat (16) @(posedge clock);

      if (fail_count == 0 && size_due_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
